// ===== rtl/core/bmhq_pkg.sv =====
// shared types and codes for the binary max heap queue
package bmhq_pkg;

  typedef enum logic [3:0] {
    S_IDLE,
    S_PU_RD,
    S_PU_CMP,
    S_PD_LAST,
    S_PD_CH,
    S_PD_L,
    S_PD_R,
    S_PD_DEC
  } state_t;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  localparam logic KIND_PUSH = 1'b0;
  localparam logic KIND_POP  = 1'b1;

  localparam int OUT_KEY_BITS   = 32;
  localparam int OUT_COUNT_BITS = 5;

endpackage

// ===== rtl/core/bmhq_ram.sv =====
// generic single write port, single read port ram with registered read
module bmhq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/core/binary_max_heap_queue_top.sv =====
// binary max heap priority queue: push and pop with sift over a single ram
//
// channel  ports                                   transfer
// input    start, busy, in_kind, in_key_value      start high while busy low
// result   out_strobe, out_status, out_removed_key, one cycle with out_strobe high
//          out_top_key, out_count, out_empty_res
//
// a push climbs from the new slot, reading each parent and moving it down while the new key is larger;
// a pop moves the last key to the root and sinks it, reading the left and then the right child, and a
// new request waits until busy falls; ram reads go through one port.
// a full push, an empty pop or a pop of the last key gives its result straight from idle, never busy.
// synchronous active-low reset clears the count; heap entries need no clearing.
// the result is shown for one cycle and cannot be held off; start is taken in that cycle.
module binary_max_heap_queue_top #(
  parameter int CAPACITY = 16,
  parameter int KEY_BITS = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic        in_kind,
  input  logic [31:0] in_key_value,
  output logic        out_strobe,
  output logic [1:0]  out_status,
  output logic [31:0] out_removed_key,
  output logic [31:0] out_top_key,
  output logic [4:0]  out_count,
  output logic        out_empty_res
);

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int IW = AW + 2;

  localparam int OUT_KEY_BITS   = bmhq_pkg::OUT_KEY_BITS;
  localparam int OUT_COUNT_BITS = bmhq_pkg::OUT_COUNT_BITS;

  bmhq_pkg::state_t  state_r, state_nxt;
  bmhq_pkg::status_t status_r, status_nxt;
  logic [CW-1:0]       cnt_r, cnt_nxt;
  logic [AW-1:0]       pos_r, pos_nxt;
  logic [KEY_BITS-1:0] key_r, key_nxt;
  logic [KEY_BITS-1:0] lv_r, lv_nxt;
  logic [KEY_BITS-1:0] rv_r, rv_nxt;
  logic                rvld_r, rvld_nxt;
  logic [KEY_BITS-1:0] top_r, top_nxt;
  logic [KEY_BITS-1:0] removed_r, removed_nxt;
  logic                strobe_r, strobe_nxt;

  logic                we;
  logic [AW-1:0]       waddr;
  logic [KEY_BITS-1:0] wdata;
  logic [AW-1:0]       raddr;
  logic [KEY_BITS-1:0] rdata;

  logic [AW-1:0]       parent;
  logic [IW-1:0]       lidx;
  logic [IW-1:0]       ridx;
  logic [IW-1:0]       n_ext;
  logic                lgt;
  logic                rgt;
  logic [KEY_BITS-1:0] best_val;

  bmhq_ram #(
    .WIDTH(KEY_BITS),
    .DEPTH(CAPACITY)
  ) u_ram (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .raddr(raddr),
    .rdata(rdata)
  );

  assign parent   = (pos_r - AW'(1)) >> 1;
  assign lidx     = (IW'(pos_r) << 1) + IW'(1);
  assign ridx     = (IW'(pos_r) << 1) + IW'(2);
  assign n_ext    = IW'(cnt_r);
  assign lgt      = lv_r > key_r;
  assign best_val = lgt ? lv_r : key_r;
  assign rgt      = rvld_r && (rv_r > best_val);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= bmhq_pkg::S_IDLE;
      cnt_r    <= '0;
      strobe_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      cnt_r    <= cnt_nxt;
      strobe_r <= strobe_nxt;
    end
  end

  always_ff @(posedge clk) begin
    status_r  <= status_nxt;
    pos_r     <= pos_nxt;
    key_r     <= key_nxt;
    lv_r      <= lv_nxt;
    rv_r      <= rv_nxt;
    rvld_r    <= rvld_nxt;
    top_r     <= top_nxt;
    removed_r <= removed_nxt;
  end

  always_comb begin
    state_nxt   = state_r;
    status_nxt  = status_r;
    cnt_nxt     = cnt_r;
    pos_nxt     = pos_r;
    key_nxt     = key_r;
    lv_nxt      = lv_r;
    rv_nxt      = rv_r;
    rvld_nxt    = rvld_r;
    removed_nxt = removed_r;
    strobe_nxt  = 1'b0;
    we          = 1'b0;
    waddr       = pos_r;
    wdata       = key_r;
    raddr       = '0;

    unique case (state_r)
      bmhq_pkg::S_IDLE: begin
        if (start) begin
          removed_nxt = '0;
          status_nxt  = bmhq_pkg::ST_DONE;
          if (in_kind == bmhq_pkg::KIND_PUSH) begin
            if (cnt_r == CW'(CAPACITY)) begin
              status_nxt = bmhq_pkg::ST_FULL;
              strobe_nxt = 1'b1;
            end else begin
              cnt_nxt   = cnt_r + CW'(1);
              pos_nxt   = AW'(cnt_r);
              key_nxt   = KEY_BITS'(in_key_value);
              state_nxt = bmhq_pkg::S_PU_RD;
            end
          end else begin
            if (cnt_r == '0) begin
              status_nxt = bmhq_pkg::ST_EMPTY;
              strobe_nxt = 1'b1;
            end else begin
              removed_nxt = top_r;
              cnt_nxt     = cnt_r - CW'(1);
              if (cnt_r == CW'(1)) begin
                strobe_nxt = 1'b1;
              end else begin
                raddr     = AW'(cnt_r - CW'(1));
                state_nxt = bmhq_pkg::S_PD_LAST;
              end
            end
          end
        end
      end
      bmhq_pkg::S_PU_RD: begin
        if (pos_r == '0) begin
          we         = 1'b1;
          strobe_nxt = 1'b1;
          state_nxt  = bmhq_pkg::S_IDLE;
        end else begin
          raddr     = parent;
          state_nxt = bmhq_pkg::S_PU_CMP;
        end
      end
      bmhq_pkg::S_PU_CMP: begin
        we = 1'b1;
        if (key_r > rdata) begin
          wdata     = rdata;
          pos_nxt   = parent;
          state_nxt = bmhq_pkg::S_PU_RD;
        end else begin
          strobe_nxt = 1'b1;
          state_nxt  = bmhq_pkg::S_IDLE;
        end
      end
      bmhq_pkg::S_PD_LAST: begin
        key_nxt   = rdata;
        pos_nxt   = '0;
        state_nxt = bmhq_pkg::S_PD_CH;
      end
      bmhq_pkg::S_PD_CH: begin
        if (lidx >= n_ext) begin
          we         = 1'b1;
          strobe_nxt = 1'b1;
          state_nxt  = bmhq_pkg::S_IDLE;
        end else begin
          raddr     = AW'(lidx);
          state_nxt = bmhq_pkg::S_PD_L;
        end
      end
      bmhq_pkg::S_PD_L: begin
        lv_nxt = rdata;
        if (ridx < n_ext) begin
          raddr     = AW'(ridx);
          rvld_nxt  = 1'b1;
          state_nxt = bmhq_pkg::S_PD_R;
        end else begin
          rvld_nxt  = 1'b0;
          state_nxt = bmhq_pkg::S_PD_DEC;
        end
      end
      bmhq_pkg::S_PD_R: begin
        rv_nxt    = rdata;
        state_nxt = bmhq_pkg::S_PD_DEC;
      end
      bmhq_pkg::S_PD_DEC: begin
        we = 1'b1;
        if (rgt) begin
          wdata     = rv_r;
          pos_nxt   = AW'(ridx);
          state_nxt = bmhq_pkg::S_PD_CH;
        end else if (lgt) begin
          wdata     = lv_r;
          pos_nxt   = AW'(lidx);
          state_nxt = bmhq_pkg::S_PD_CH;
        end else begin
          strobe_nxt = 1'b1;
          state_nxt  = bmhq_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = bmhq_pkg::S_IDLE;
      end
    endcase
  end

  // root shadow follows every write to the root slot
  always_comb begin
    top_nxt = top_r;
    if (we && (waddr == '0)) begin
      top_nxt = wdata;
    end
  end

  assign busy            = (state_r != bmhq_pkg::S_IDLE);
  assign out_strobe      = strobe_r;
  assign out_status      = status_r;
  assign out_removed_key = OUT_KEY_BITS'(removed_r);
  assign out_top_key     = (cnt_r == '0) ? '0 : OUT_KEY_BITS'(top_r);
  assign out_count       = OUT_COUNT_BITS'(cnt_r);
  assign out_empty_res   = (cnt_r == '0);

`ifndef SYNTHESIS
  a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> !busy)
    else $error("result shown while busy");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(CAPACITY))
    else $error("count above capacity");

  a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && (out_status == bmhq_pkg::ST_FULL)) |-> (cnt_r == CW'(CAPACITY)))
    else $error("full status with room left");

  a_empty_status: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && (out_status == bmhq_pkg::ST_EMPTY)) |-> (cnt_r == '0))
    else $error("empty status with keys stored");

  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    (busy && !$past(busy)) |-> (cnt_r != $past(cnt_r)))
    else $error("count not updated on transfer");
`endif

endmodule
